// ===== rtl/rws_pkg.sv =====
// Shared constants, widths and controller/datapath signal bundles for the RSI stream block.
`default_nettype none
package rws_pkg;

  // Field and arithmetic widths.
  localparam int PRICE_W       = 32;
  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_W         = PRICE_BITS + FRACTION_BITS;
  localparam int ALPHA_W       = 17;
  localparam int ALPHA_FRAC    = 16;
  localparam int MUL_A_W       = AVG_W - ALPHA_FRAC;
  localparam int PROD_W        = MUL_A_W + ALPHA_W;
  localparam int SUM_W         = AVG_W + 1;
  localparam int REM_W         = SUM_W + 2;
  localparam int RSI_W         = 23;
  localparam int CNT_W         = $clog2(RSI_W);

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_COEFF = 1'b0;

  // Constants of the arithmetic.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << ALPHA_FRAC);
  localparam logic [ALPHA_W-1:0] COEFF_RESET = ALPHA_W'(4681);
  localparam logic [PROD_W-1:0]  LO_ROUND    = PROD_W'((1 << ALPHA_FRAC) - 1);
  localparam logic [RSI_W-1:0]   RSI_FULL    = RSI_W'(6553600);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             delta;
    logic             diff;
    logic             mul_hi;
    logic             mul_lo;
    logic             upd;
    logic             div_init;
    logic             div_step;
    logic             load_out;
    logic             side;
    logic [CNT_W-1:0] bit_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first;
    logic loss_zero;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/rws_price_if.sv =====
// Input channel carrying one closing price per transaction.
`default_nettype none
interface rws_price_if;
  logic                        valid;
  logic                        ready;
  logic [rws_pkg::PRICE_W-1:0] price;
  logic                        series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink (input valid, input price, input series_start, output ready);
endinterface
`default_nettype wire

// ===== rtl/rws_result_if.sv =====
// Output channel carrying one RSI value per transaction.
`default_nettype none
interface rws_result_if;
  logic                      valid;
  logic                      ready;
  logic [rws_pkg::RSI_W-1:0] rsi_value;

  modport source (output valid, output rsi_value, input ready);
  modport sink (input valid, input rsi_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rsi_wilder_stream.sv =====
// Streaming RSI with Wilder smoothing: one price per transaction, items processed one at a time.
// Sequence to the output transaction: delta, then for a first price the output load; else two
// smoothing passes (difference, high multiply, low multiply, update) on one shared 32x17
// multiplier, divider setup, 23 radix-2 divider steps unless the loss average is zero, output
// load. A new price is accepted only after that load, and a result held at the output stalls it.
// Reset (synchronous, rst_n low) clears the sequencer and the series flag; coefficient is 4681.
`default_nettype none
module rsi_wilder_stream (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rws_price_if.sink                             in_st,
  rws_result_if.source                          out_st,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rws_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rws_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  logic [rws_pkg::ALPHA_W-1:0] coeff_r, coeff_nxt;
  logic                        cfg_wr;
  rws_pkg::cmd_t               cmd;
  rws_pkg::status_t            status;

  // Configuration register: written in the access phase of a transaction to its address.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == rws_pkg::CFG_IDX_COEFF);
  assign coeff_nxt = cfg_wr ? pwdata[rws_pkg::ALPHA_W-1:0] : coeff_r;
  assign prdata = (paddr[2] == rws_pkg::CFG_IDX_COEFF) ? rws_pkg::CFG_DATA_W'(coeff_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= rws_pkg::COEFF_RESET;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_st.valid),
    .in_ready  (in_st.ready),
    .out_valid (out_st.valid),
    .out_ready (out_st.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rws_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .price        (in_st.price),
    .series_start (in_st.series_start),
    .coeff        (coeff_r),
    .cmd          (cmd),
    .status       (status),
    .rsi_value    (out_st.rsi_value)
  );

endmodule
`default_nettype wire

// ===== rtl/rws_datapath.sv =====
// Datapath: price delta, shared multiplier for Wilder smoothing, bit-serial scaled divider.
`default_nettype none
module rws_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [rws_pkg::PRICE_W-1:0]    price,
  input  wire logic                           series_start,
  input  wire logic [rws_pkg::ALPHA_W-1:0]    coeff,
  input  wire rws_pkg::cmd_t                  cmd,
  output rws_pkg::status_t                    status,
  output logic [rws_pkg::RSI_W-1:0]           rsi_value
);

  logic [rws_pkg::PRICE_BITS-1:0] price_r;
  logic                           start_r;
  logic [rws_pkg::PRICE_BITS-1:0] last_r, last_nxt;
  logic                           have_last_r, have_last_nxt;
  logic [rws_pkg::AVG_W-1:0]      gain_r, gain_nxt;
  logic [rws_pkg::AVG_W-1:0]      loss_r, loss_nxt;
  logic [rws_pkg::AVG_W-1:0]      xg_r, xg_nxt;
  logic [rws_pkg::AVG_W-1:0]      xl_r, xl_nxt;
  logic [rws_pkg::AVG_W-1:0]      m_r, m_nxt;
  logic                           pos_r, pos_nxt;
  logic [rws_pkg::PROD_W-1:0]     hi_r, lo_r;
  logic [rws_pkg::SUM_W-1:0]      den_r, den_nxt;
  logic [rws_pkg::SUM_W-1:0]      rem_r, rem_nxt;
  logic [rws_pkg::RSI_W-1:0]      q_r, q_nxt;
  logic [rws_pkg::RSI_W-1:0]      out_rsi_r;

  logic                           first;
  logic [rws_pkg::ALPHA_W-1:0]    alpha;
  logic [rws_pkg::AVG_W-1:0]      avg_sel, x_sel;
  logic [rws_pkg::MUL_A_W-1:0]    mul_a;
  logic [rws_pkg::PROD_W-1:0]     prod;
  logic [rws_pkg::PROD_W-1:0]     lo_sum, step;
  logic [rws_pkg::AVG_W-1:0]      avg_new;
  logic [rws_pkg::REM_W-1:0]      r2, d1, d2, addend;

  // Saturate the coefficient so that alpha never exceeds one.
  assign alpha = (coeff > rws_pkg::ALPHA_ONE) ? rws_pkg::ALPHA_ONE : coeff;

  assign first            = start_r | ~have_last_r;
  assign status.first     = first;
  assign status.loss_zero = (loss_r == '0);

  // Operands of the average being worked on.
  assign avg_sel = cmd.side ? loss_r : gain_r;
  assign x_sel   = cmd.side ? xl_r : xg_r;

  // One shared multiplier: upper part of the difference first, low 16 bits next.
  assign mul_a = cmd.mul_hi ? m_r[rws_pkg::AVG_W-1:rws_pkg::ALPHA_FRAC]
                            : rws_pkg::MUL_A_W'(m_r[rws_pkg::ALPHA_FRAC-1:0]);
  assign prod  = rws_pkg::PROD_W'(mul_a) * rws_pkg::PROD_W'(alpha);

  // Floor of alpha times the signed difference: round the low part up when negative.
  assign lo_sum  = pos_r ? lo_r : lo_r + rws_pkg::LO_ROUND;
  assign step    = hi_r + (lo_sum >> rws_pkg::ALPHA_FRAC);
  assign avg_new = pos_r ? avg_sel + step[rws_pkg::AVG_W-1:0]
                         : avg_sel - step[rws_pkg::AVG_W-1:0];

  // One digit of the scaled ratio: the partial remainder stays below three denominators.
  assign addend = rws_pkg::RSI_FULL[cmd.bit_idx] ? rws_pkg::REM_W'(gain_r) : '0;
  assign r2     = {1'b0, rem_r, 1'b0} + addend;
  assign d1     = rws_pkg::REM_W'(den_r);
  assign d2     = {1'b0, den_r, 1'b0};

  always_comb begin
    last_nxt      = last_r;
    have_last_nxt = have_last_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    xg_nxt        = xg_r;
    xl_nxt        = xl_r;
    m_nxt         = m_r;
    pos_nxt       = pos_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;

    // Price move, or a restart of the series.
    if (cmd.delta) begin
      last_nxt      = price_r;
      have_last_nxt = 1'b1;
      if (first) begin
        gain_nxt = '0;
        loss_nxt = '0;
        q_nxt    = rws_pkg::RSI_FULL;
      end else if (price_r > last_r) begin
        xg_nxt = {price_r - last_r, {rws_pkg::FRACTION_BITS{1'b0}}};
        xl_nxt = '0;
      end else begin
        xg_nxt = '0;
        xl_nxt = {last_r - price_r, {rws_pkg::FRACTION_BITS{1'b0}}};
      end
    end

    // Magnitude and sign of the target minus the average.
    if (cmd.diff) begin
      pos_nxt = (x_sel >= avg_sel);
      m_nxt   = (x_sel >= avg_sel) ? x_sel - avg_sel : avg_sel - x_sel;
    end

    // Write back the smoothed average.
    if (cmd.upd) begin
      if (cmd.side) begin
        loss_nxt = avg_new;
      end else begin
        gain_nxt = avg_new;
      end
    end

    // Divider setup; a zero loss average gives the full-scale result.
    if (cmd.div_init) begin
      den_nxt = rws_pkg::SUM_W'(gain_r) + rws_pkg::SUM_W'(loss_r);
      rem_nxt = '0;
      q_nxt   = (loss_r == '0) ? rws_pkg::RSI_FULL : '0;
    end

    // Quotient digit is zero, one or two.
    if (cmd.div_step) begin
      if (r2 >= d2) begin
        rem_nxt = rws_pkg::SUM_W'(r2 - d2);
        q_nxt   = {q_r[rws_pkg::RSI_W-2:0], 1'b0} + rws_pkg::RSI_W'(2);
      end else if (r2 >= d1) begin
        rem_nxt = rws_pkg::SUM_W'(r2 - d1);
        q_nxt   = {q_r[rws_pkg::RSI_W-2:0], 1'b0} + rws_pkg::RSI_W'(1);
      end else begin
        rem_nxt = rws_pkg::SUM_W'(r2);
        q_nxt   = {q_r[rws_pkg::RSI_W-2:0], 1'b0};
      end
    end
  end

  // Series state; only the have-last flag needs reset since a first price clears the rest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
    end else begin
      have_last_r <= have_last_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      price_r <= price[rws_pkg::PRICE_BITS-1:0];
      start_r <= series_start;
    end
    if (cmd.mul_hi) begin
      hi_r <= prod;
    end
    if (cmd.mul_lo) begin
      lo_r <= prod;
    end
    if (cmd.load_out) begin
      out_rsi_r <= q_r;
    end
    last_r <= last_nxt;
    gain_r <= gain_nxt;
    loss_r <= loss_nxt;
    xg_r   <= xg_nxt;
    xl_r   <= xl_nxt;
    m_r    <= m_nxt;
    pos_r  <= pos_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign rsi_value = out_rsi_r;

endmodule
`default_nettype wire

// ===== rtl/rws_ctrl.sv =====
// Controller: sequences delta, two smoothing passes, the divider and the output register.
`default_nettype none
module rws_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire rws_pkg::status_t     status,
  output rws_pkg::cmd_t             cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DELTA = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_MULH  = 9'b000001000,
    S_MULL  = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_DINIT = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      side_r, side_nxt;
  logic [rws_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      slot_free;

  // The result register can take a new value when empty or emptying this cycle.
  assign slot_free = ~out_valid_r | out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    side_nxt     = side_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.side     = side_r;
    cmd.bit_idx  = cnt_r;

    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        side_nxt  = 1'b0;
        state_nxt = status.first ? S_DONE : S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MULH;
      end
      S_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MULL;
      end
      S_MULL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (side_r) begin
          state_nxt = S_DINIT;
        end else begin
          side_nxt  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = rws_pkg::CNT_W'(rws_pkg::RSI_W - 1);
        state_nxt    = status.loss_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - rws_pkg::CNT_W'(1);
        end
      end
      S_DONE: begin
        cmd.load_out = slot_free;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and consumer transactions.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire
